// ===== rtl/cma_pkg.sv =====
// shared types and constants of the class moment accumulator
package cma_pkg;

	// field and store widths
	localparam int VAL_W  = 32;
	localparam int WGT_W  = 16;
	localparam int CNT_W  = 48;
	localparam int SUM_W  = 56;
	localparam int PAIR_W = 64;

	// 1.0 in Q16.16, used to turn the product unit into a plain x*w
	localparam logic signed [VAL_W-1:0] VAL_ONE = 32'sh0001_0000;

	// saturation limits of the sum and pair stores
	localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
	localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};
	localparam logic signed [PAIR_W-1:0] PAIR_MAX = {1'b0, {(PAIR_W-1){1'b1}}};
	localparam logic signed [PAIR_W-1:0] PAIR_MIN = {1'b1, {(PAIR_W-1){1'b0}}};

	// pair modes
	localparam logic [1:0] PM_FULL = 2'd0;
	localparam logic [1:0] PM_DIAG = 2'd1;

	// configuration register indexes
	localparam logic [1:0] REG_DIMS    = 2'd0;
	localparam logic [1:0] REG_MODE    = 2'd1;
	localparam logic [1:0] REG_CLASSES = 2'd2;

	typedef enum logic [2:0] {
		CMD_ACC     = 3'd0,
		CMD_SUB     = 3'd1,
		CMD_MOVE    = 3'd2,
		CMD_CLR     = 3'd3,
		CMD_RD_CNT  = 3'd4,
		CMD_RD_SUM  = 3'd5,
		CMD_RD_PAIR = 3'd6
	} cmd_t;

	typedef enum logic [1:0] {
		STS_OK     = 2'd0,
		STS_RANGE  = 2'd1,
		STS_REJECT = 2'd2,
		STS_SAT    = 2'd3
	} status_t;

	typedef enum logic [3:0] {
		S_CLR,
		S_IDLE,
		S_EL_MUL,
		S_EL_WR,
		S_EL_BUF,
		S_EL_LDB,
		S_EL_MIR,
		S_EL_MWR,
		S_EL_FIN,
		S_MV_RSRC,
		S_MV_RDST,
		S_MV_WDST,
		S_MV_WSRC,
		S_RD_WAIT,
		S_DONE
	} state_t;

	// operands of the weighted product unit
	typedef struct packed {
		logic signed [VAL_W-1:0] a;
		logic signed [VAL_W-1:0] b;
		logic [WGT_W-1:0]        w;
		logic                    neg;
	} mul_req_t;

endpackage

// ===== rtl/class_moment_accumulator.sv =====
// top level of the class moment accumulator
//
// channel  direction  handshake            payload
// in       input      in_valid/in_ready    cmd class_id target_class sample_value weight
//                                          row_index col_index
// out      output     out_valid/out_ready  status read_data
// cfg      input      cfg_valid/cfg_ready  cfg_index cfg_data
//
// after reset a clearing pass zeroes the stores; clear all takes the same pass. an
// element at position i in full mode takes partners 0 to i, with one pass through the
// shared product unit and two memory turns per pair; diagonal mode takes only the
// diagonal pair, and other modes no pairs. redistribute walks every entry of the class.
// one item is worked at a time; the result register lets the next item in while the
// last result waits on out_ready.
module class_moment_accumulator #(
	parameter int DIM     = 16,
	parameter int CLASSES = 8
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [2:0]          cmd,
	input  logic [2:0]          class_id,
	input  logic [2:0]          target_class,
	input  logic signed [31:0]  sample_value,
	input  logic [15:0]         weight,
	input  logic [3:0]          row_index,
	input  logic [3:0]          col_index,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [1:0]          status,
	output logic signed [63:0]  read_data,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [1:0]          cfg_index,
	input  logic [7:0]          cfg_data
);
	import cma_pkg::*;

	localparam int PD  = CLASSES * DIM * DIM;
	localparam int SD  = CLASSES * DIM;
	localparam int PAW = (PD > 1) ? $clog2(PD) : 1;
	localparam int SAW = (SD > 1) ? $clog2(SD) : 1;
	localparam int BAW = (DIM > 1) ? $clog2(DIM) : 1;
	localparam int CW  = (CLASSES > 1) ? $clog2(CLASSES) : 1;

	// configuration
	logic [4:0] cfg_dims_q;
	logic [1:0] cfg_mode_q;
	logic [3:0] cfg_cls_q;

	// control and item registers
	state_t                    state_q, state_d;
	logic [2:0]                c_q, k_q;
	logic signed [VAL_W-1:0]   x_q;
	logic [WGT_W-1:0]          w_q;
	logic                      sub_q;
	logic [BAW-1:0]            pos_q, epos_q, j_q;
	logic                      rej_q, last_q, ph_q, clr_reply_q, sat_q;
	logic [1:0]                mw_q;
	logic [PAW-1:0]            n_q;
	logic                      rdok_q, rdsum_q;
	logic [1:0]                sts_q;
	logic signed [63:0]        dat_q;
	logic [CNT_W-1:0]          srcc_q;
	logic signed [SUM_W-1:0]   srcs_q;
	logic signed [PAIR_W-1:0]  srcp_q;
	logic signed [VAL_W-1:0]   mul_a_q, mul_b_q;
	logic [CNT_W-1:0]          cnt_q [CLASSES];
	logic                      out_valid_q;
	logic [1:0]                status_q;
	logic signed [63:0]        read_data_q;

	// memories
	logic signed [VAL_W-1:0]   buf_mem [DIM];
	logic signed [SUM_W-1:0]   sum_mem [SD];
	logic signed [PAIR_W-1:0]  pair_mem [PD];
	logic signed [VAL_W-1:0]   buf_rd_q;
	logic signed [SUM_W-1:0]   sum_rd_q;
	logic signed [PAIR_W-1:0]  pair_rd_q;

	logic                      buf_we, sum_we, pair_we;
	logic [SAW-1:0]            sum_raddr, sum_waddr;
	logic [PAW-1:0]            pair_raddr, pair_waddr;
	logic signed [SUM_W-1:0]   sum_wdata;
	logic signed [PAIR_W-1:0]  pair_wdata;
	logic [CW-1:0]             cnt_idx;
	logic [CNT_W-1:0]          cnt_rd;

	// arithmetic
	mul_req_t                  mreq;
	logic signed [PAIR_W-1:0]  prod;
	logic signed [PAIR_W-1:0]  sum_op, pair_op;
	logic [CNT_W-1:0]          cnt_op;
	logic signed [SUM_W-1:0]   sum_new;
	logic signed [PAIR_W-1:0]  pair_new;
	logic [CNT_W-1:0]          cnt_new;
	logic                      sum_ovf, pair_ovf, cnt_ovf;

	// decode of the offered item
	logic [6:0]                cls_eff, dims_eff;
	logic                      c_ok, k_ok, el_last, el_over, el_go, row_ok, col_ok, mode_ok;
	logic                      move_lastn, n_sum;

	function automatic logic [PAW-1:0] p_addr(input int cls, input int r, input int col);
		return PAW'(cls * DIM * DIM + r * DIM + col);
	endfunction

	function automatic logic [SAW-1:0] s_addr(input int cls, input int r);
		return SAW'(cls * DIM + r);
	endfunction

	function automatic logic signed [SUM_W-1:0] sat_sum(input logic signed [SUM_W-1:0] a,
			input logic signed [PAIR_W-1:0] b, output logic ovf);
		logic signed [PAIR_W:0] s;
		s = 65'(a) + 65'(b);
		ovf = (s > 65'(SUM_MAX)) || (s < 65'(SUM_MIN));
		if (s > 65'(SUM_MAX))
			return SUM_MAX;
		if (s < 65'(SUM_MIN))
			return SUM_MIN;
		return s[SUM_W-1:0];
	endfunction

	function automatic logic signed [PAIR_W-1:0] sat_pair(input logic signed [PAIR_W-1:0] a,
			input logic signed [PAIR_W-1:0] b, output logic ovf);
		logic signed [PAIR_W:0] s;
		s = 65'(a) + 65'(b);
		ovf = s[PAIR_W] != s[PAIR_W-1];
		if (ovf)
			return s[PAIR_W] ? PAIR_MIN : PAIR_MAX;
		return s[PAIR_W-1:0];
	endfunction

	function automatic logic [CNT_W-1:0] sat_cnt(input logic [CNT_W-1:0] a,
			input logic [CNT_W-1:0] b, output logic ovf);
		logic [CNT_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		ovf = s[CNT_W];
		return ovf ? {CNT_W{1'b1}} : s[CNT_W-1:0];
	endfunction

	// shared product unit
	assign mreq = '{a: mul_a_q, b: mul_b_q, w: w_q, neg: sub_q};

	cma_wprod u_wprod (
		.clk     (clk),
		.req     (mreq),
		.prod_s3 (prod)
	);

	// configuration writes
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_dims_q <= 5'd16;
			cfg_mode_q <= PM_FULL;
			cfg_cls_q  <= 4'd8;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_DIMS:    cfg_dims_q <= cfg_data[4:0];
				REG_MODE:    cfg_mode_q <= cfg_data[1:0];
				REG_CLASSES: cfg_cls_q  <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	// item decode
	always_comb begin
		cls_eff  = (7'(cfg_cls_q) < 7'(CLASSES)) ? 7'(cfg_cls_q) : 7'(CLASSES);
		if (cfg_dims_q == 5'd0)
			dims_eff = 7'd1;
		else if (7'(cfg_dims_q) > 7'(DIM))
			dims_eff = 7'(DIM);
		else
			dims_eff = 7'(cfg_dims_q);
		c_ok     = 7'(class_id) < cls_eff;
		k_ok     = 7'(target_class) < cls_eff;
		el_last  = (7'(pos_q) + 7'd1) >= dims_eff;
		el_over  = (cmd_t'(cmd) == CMD_SUB) && (48'(weight) > cnt_rd);
		el_go    = c_ok && !rej_q && !el_over;
		row_ok   = 7'(row_index) < 7'(DIM);
		col_ok   = 7'(col_index) < 7'(DIM);
		mode_ok  = (cfg_mode_q == PM_FULL) || ((cfg_mode_q == PM_DIAG) && (row_index == col_index));
		move_lastn = n_q == PAW'(DIM * DIM - 1);
		n_sum    = int'(n_q) < DIM;
	end

	assign cnt_rd = cnt_q[cnt_idx];

	// saturating adders
	always_comb begin
		sum_op  = (state_q == S_MV_WDST) ? 64'(srcs_q) : prod;
		pair_op = (state_q == S_MV_WDST) ? srcp_q : prod;
		cnt_op  = (state_q == S_EL_FIN) ? 48'(w_q) : srcc_q;
		sum_new  = sat_sum(sum_rd_q, sum_op, sum_ovf);
		pair_new = sat_pair(pair_rd_q, pair_op, pair_ovf);
		cnt_new  = sat_cnt(cnt_rd, cnt_op, cnt_ovf);
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_CLR:
				if (n_q == PAW'(PD - 1))
					state_d = clr_reply_q ? S_DONE : S_IDLE;
			S_IDLE:
				if (in_valid) begin
					case (cmd_t'(cmd))
						CMD_ACC, CMD_SUB: state_d = el_go ? S_EL_MUL : S_DONE;
						CMD_MOVE: begin
							if (c_ok && k_ok)
								state_d = (class_id != target_class) ? S_MV_RSRC : S_MV_WSRC;
							else
								state_d = S_DONE;
						end
						CMD_CLR:     state_d = S_CLR;
						CMD_RD_SUM:  state_d = S_RD_WAIT;
						CMD_RD_PAIR: state_d = S_RD_WAIT;
						default:     state_d = S_DONE;
					endcase
				end
			S_EL_MUL:
				if (mw_q == 2'd2)
					state_d = S_EL_WR;
			S_EL_WR: begin
				if (!ph_q)
					state_d = (cfg_mode_q == PM_FULL || cfg_mode_q == PM_DIAG) ? S_EL_BUF : S_EL_FIN;
				else
					state_d = (j_q != epos_q) ? S_EL_MIR : S_EL_FIN;
			end
			S_EL_BUF:  state_d = S_EL_LDB;
			S_EL_LDB:  state_d = S_EL_MUL;
			S_EL_MIR:  state_d = S_EL_MWR;
			S_EL_MWR:  state_d = S_EL_BUF;
			S_EL_FIN:  state_d = S_DONE;
			S_MV_RSRC: state_d = S_MV_RDST;
			S_MV_RDST: state_d = S_MV_WDST;
			S_MV_WDST: state_d = S_MV_WSRC;
			S_MV_WSRC: begin
				if (move_lastn)
					state_d = S_DONE;
				else
					state_d = (c_q != k_q) ? S_MV_RSRC : S_MV_WSRC;
			end
			S_RD_WAIT: state_d = S_DONE;
			S_DONE:
				if (!out_valid_q || out_ready)
					state_d = S_IDLE;
			default:   state_d = S_IDLE;
		endcase
	end

	// memory controls
	always_comb begin
		in_ready   = 1'b0;
		buf_we     = 1'b0;
		sum_we     = 1'b0;
		pair_we    = 1'b0;
		sum_waddr  = s_addr(int'(c_q), int'(epos_q));
		pair_waddr = p_addr(int'(c_q), int'(epos_q), int'(j_q));
		sum_wdata  = '0;
		pair_wdata = '0;
		sum_raddr  = s_addr(int'(c_q), int'(epos_q));
		pair_raddr = p_addr(int'(c_q), int'(epos_q), int'(j_q));
		cnt_idx    = CW'(int'(c_q));
		case (state_q)
			S_CLR: begin
				sum_we     = int'(n_q) < SD;
				sum_waddr  = SAW'(n_q);
				pair_we    = 1'b1;
				pair_waddr = n_q;
			end
			S_IDLE: begin
				in_ready   = 1'b1;
				buf_we     = in_valid && (cmd_t'(cmd) == CMD_ACC || cmd_t'(cmd) == CMD_SUB);
				sum_raddr  = s_addr(int'(class_id), int'(row_index));
				pair_raddr = p_addr(int'(class_id), int'(row_index), int'(col_index));
				cnt_idx    = CW'(int'(class_id));
			end
			S_EL_WR: begin
				if (ph_q) begin
					pair_we    = 1'b1;
					pair_wdata = pair_new;
				end else begin
					sum_we    = 1'b1;
					sum_wdata = sum_new;
				end
			end
			S_EL_MIR:
				pair_raddr = p_addr(int'(c_q), int'(j_q), int'(epos_q));
			S_EL_MWR: begin
				pair_we    = 1'b1;
				pair_waddr = p_addr(int'(c_q), int'(j_q), int'(epos_q));
				pair_wdata = pair_new;
			end
			S_MV_RSRC: begin
				sum_raddr  = s_addr(int'(c_q), int'(n_q));
				pair_raddr = PAW'(int'(c_q) * DIM * DIM + int'(n_q));
			end
			S_MV_RDST: begin
				sum_raddr  = s_addr(int'(k_q), int'(n_q));
				pair_raddr = PAW'(int'(k_q) * DIM * DIM + int'(n_q));
			end
			S_MV_WDST: begin
				sum_we     = n_sum;
				sum_waddr  = s_addr(int'(k_q), int'(n_q));
				sum_wdata  = sum_new;
				pair_we    = 1'b1;
				pair_waddr = PAW'(int'(k_q) * DIM * DIM + int'(n_q));
				pair_wdata = pair_new;
			end
			S_MV_WSRC: begin
				sum_we     = n_sum;
				sum_waddr  = s_addr(int'(c_q), int'(n_q));
				pair_we    = 1'b1;
				pair_waddr = PAW'(int'(c_q) * DIM * DIM + int'(n_q));
				cnt_idx    = CW'(int'(k_q));
			end
			default: ;
		endcase
	end

	// sample buffer
	always_ff @(posedge clk) begin
		if (buf_we)
			buf_mem[pos_q] <= sample_value;
		buf_rd_q <= buf_mem[j_q];
	end

	// sum store
	always_ff @(posedge clk) begin
		if (sum_we)
			sum_mem[sum_waddr] <= sum_wdata;
		sum_rd_q <= sum_mem[sum_raddr];
	end

	// pair store
	always_ff @(posedge clk) begin
		if (pair_we)
			pair_mem[pair_waddr] <= pair_wdata;
		pair_rd_q <= pair_mem[pair_raddr];
	end

	// sequencer registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLR;
			c_q         <= '0;
			k_q         <= '0;
			x_q         <= '0;
			w_q         <= '0;
			sub_q       <= 1'b0;
			pos_q       <= '0;
			epos_q      <= '0;
			j_q         <= '0;
			rej_q       <= 1'b0;
			last_q      <= 1'b0;
			ph_q        <= 1'b0;
			clr_reply_q <= 1'b0;
			sat_q       <= 1'b0;
			mw_q        <= '0;
			n_q         <= '0;
			rdok_q      <= 1'b0;
			rdsum_q     <= 1'b0;
			sts_q       <= STS_OK;
			dat_q       <= '0;
			srcc_q      <= '0;
			srcs_q      <= '0;
			srcp_q      <= '0;
			mul_a_q     <= '0;
			mul_b_q     <= '0;
			out_valid_q <= 1'b0;
			status_q    <= STS_OK;
			read_data_q <= '0;
			for (int i = 0; i < CLASSES; i++)
				cnt_q[i] <= '0;
		end else begin
			state_q <= state_d;
			if (out_valid_q && out_ready)
				out_valid_q <= 1'b0;
			case (state_q)
				// clearing pass
				S_CLR: begin
					n_q   <= n_q + 1'b1;
					pos_q <= '0;
					rej_q <= 1'b0;
					for (int i = 0; i < CLASSES; i++)
						cnt_q[i] <= '0;
				end
				// take a new item
				S_IDLE:
					if (in_valid) begin
						c_q         <= class_id;
						k_q         <= target_class;
						x_q         <= sample_value;
						w_q         <= weight;
						sub_q       <= cmd_t'(cmd) == CMD_SUB;
						dat_q       <= '0;
						sts_q       <= STS_OK;
						sat_q       <= 1'b0;
						n_q         <= '0;
						mw_q        <= '0;
						ph_q        <= 1'b0;
						mul_a_q     <= sample_value;
						mul_b_q     <= VAL_ONE;
						clr_reply_q <= 1'b0;
						rdok_q      <= 1'b0;
						case (cmd_t'(cmd))
							CMD_ACC, CMD_SUB: begin
								epos_q <= pos_q;
								last_q <= el_last;
								if (el_last) begin
									pos_q <= '0;
									rej_q <= 1'b0;
								end else begin
									pos_q <= pos_q + 1'b1;
									rej_q <= rej_q || !c_ok || el_over;
								end
								if (!c_ok)
									sts_q <= STS_RANGE;
								else if (rej_q || el_over)
									sts_q <= STS_REJECT;
							end
							CMD_MOVE: begin
								srcc_q <= cnt_rd;
								if (!c_ok || !k_ok)
									sts_q <= STS_RANGE;
							end
							CMD_CLR:
								clr_reply_q <= 1'b1;
							CMD_RD_CNT: begin
								if (!c_ok)
									sts_q <= STS_RANGE;
								else
									dat_q <= 64'(cnt_rd);
							end
							CMD_RD_SUM: begin
								rdsum_q <= 1'b1;
								rdok_q  <= c_ok && row_ok;
								if (!c_ok)
									sts_q <= STS_RANGE;
							end
							CMD_RD_PAIR: begin
								rdsum_q <= 1'b0;
								rdok_q  <= c_ok && row_ok && col_ok && mode_ok;
								if (!c_ok)
									sts_q <= STS_RANGE;
							end
							default: ;
						endcase
					end
				// wait out the product unit
				S_EL_MUL:
					mw_q <= mw_q + 1'b1;
				// sum or pair write back
				S_EL_WR: begin
					if (ph_q) begin
						sat_q <= sat_q | pair_ovf;
					end else begin
						sat_q <= sat_q | sum_ovf;
						ph_q  <= 1'b1;
						j_q   <= (cfg_mode_q == PM_FULL) ? '0 : epos_q;
					end
				end
				// load the buffered partner element
				S_EL_LDB: begin
					mul_a_q <= x_q;
					mul_b_q <= (j_q == epos_q) ? x_q : buf_rd_q;
					mw_q    <= '0;
				end
				// mirrored entry written, next partner
				S_EL_MWR: begin
					sat_q <= sat_q | pair_ovf;
					j_q   <= j_q + 1'b1;
				end
				// count update on the last element
				S_EL_FIN: begin
					if (last_q) begin
						if (sub_q)
							cnt_q[c_q[CW-1:0]] <= cnt_rd - 48'(w_q);
						else
							cnt_q[c_q[CW-1:0]] <= cnt_new;
					end
					sts_q <= (sat_q || (last_q && !sub_q && cnt_ovf)) ? STS_SAT : STS_OK;
				end
				// redistribute walk
				S_MV_RDST: begin
					srcs_q <= sum_rd_q;
					srcp_q <= pair_rd_q;
				end
				S_MV_WDST:
					sat_q <= sat_q | pair_ovf | (n_sum & sum_ovf);
				S_MV_WSRC: begin
					n_q <= n_q + 1'b1;
					if (move_lastn) begin
						cnt_q[c_q[CW-1:0]] <= '0;
						if (c_q != k_q)
							cnt_q[k_q[CW-1:0]] <= cnt_new;
						sts_q <= (sat_q || ((c_q != k_q) && cnt_ovf)) ? STS_SAT : STS_OK;
					end
				end
				// read data from the stores
				S_RD_WAIT: begin
					if (rdok_q)
						dat_q <= rdsum_q ? 64'(sum_rd_q) : pair_rd_q;
					else
						dat_q <= '0;
				end
				// hand the result to the output register
				S_DONE:
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						status_q    <= sts_q;
						read_data_q <= dat_q;
					end
				default: ;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign read_data = read_data_q;

	// a waiting result is never overwritten
	a_done_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE && out_valid_q && !out_ready) |=> (state_q == S_DONE))
		else $error("result register overwritten");

	// position stays inside the sample buffer
	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		int'(pos_q) < DIM)
		else $error("element position out of range");

	// partner index never passes the current element
	a_j_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(ph_q && (state_q == S_EL_BUF || state_q == S_EL_MIR || state_q == S_EL_MWR))
		|-> (j_q <= epos_q))
		else $error("pair partner beyond element");

	// no transfer is taken during the clearing pass
	a_clr_block: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CLR) |-> !in_ready)
		else $error("input taken while clearing");

	// a mirrored write always follows a pair write of a lower partner
	a_mirror: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EL_MIR) |-> ($past(state_q) == S_EL_WR && j_q != epos_q))
		else $error("mirror step out of order");

endmodule

// ===== rtl/cma_wprod.sv =====
// three-stage weighted product unit: +-floor(a*b / 2^16) * w
module cma_wprod (
	input  logic                                clk,
	input  cma_pkg::mul_req_t                   req,
	output logic signed [cma_pkg::PAIR_W-1:0]   prod_s3
);
	import cma_pkg::*;

	logic signed [2*VAL_W-1:0] p_s1;
	logic [WGT_W-1:0]          w_s1;
	logic                      neg_s1;
	logic [47:0]               lo_s2;
	logic signed [32:0]        hi_s2;
	logic                      neg_s2;
	logic signed [47:0]        sh;
	logic signed [PAIR_W-1:0]  tot;

	// floor shift is the arithmetic shift, i.e. the upper 48 bits
	assign sh  = p_s1[63:16];
	assign tot = {hi_s2[31:0], 32'd0} + {16'd0, lo_s2};

	// stage 1: full signed product
	always_ff @(posedge clk) begin
		p_s1   <= 64'(req.a) * 64'(req.b);
		w_s1   <= req.w;
		neg_s1 <= req.neg;
	end

	// stage 2: weight product split into two partial products
	always_ff @(posedge clk) begin
		lo_s2  <= 48'(sh[31:0]) * 48'(w_s1);
		hi_s2  <= 33'($signed(sh[47:32])) * 33'($signed({1'b0, w_s1}));
		neg_s2 <= neg_s1;
	end

	// stage 3: combine and apply sign
	always_ff @(posedge clk) begin
		prod_s3 <= neg_s2 ? -tot : tot;
	end

endmodule
